FILE: rtl/qae_pkg.sv
// Shared widths and a helper function for the quaternion attitude error pipeline.
package qae_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;                 // input component width
  localparam int OUT_W      = 16;                 // output component width
  localparam int SQ_W       = 2 * IN_W - 1;       // one squared component
  localparam int SUM_W      = SQ_W + 2;           // sum of four squares
  localparam int SQRT_STEPS = (SUM_W + 1) / 2;    // one root bit per stage
  localparam int SQRT_IN_W  = 2 * SQRT_STEPS;
  localparam int LEN_W      = SQRT_STEPS;         // quaternion length
  localparam int REM_W      = LEN_W + 2;          // root remainder
  localparam int MAG_W      = IN_W;               // |component|, max 2^15
  localparam int NUM_W      = MAG_W + 1 + FRAC_BITS + 1;
  localparam int DIV_STEPS  = FRAC_BITS + 1;      // quotient bits
  localparam int NRM_W      = FRAC_BITS + 2;      // normalized component, signed
  localparam int PROD_W     = 2 * NRM_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NORM_DEPTH = 4 + SQRT_STEPS + DIV_STEPS;
  localparam int PIPE_DEPTH = 1 + NORM_DEPTH + 3;

  typedef logic signed [IN_W-1:0]  comp_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [LEN_W-1:0] root;
  } sqrt_st_t;

  // one digit of the restoring square root: two radicand bits in, one root bit out
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [1:0] bits);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sqrt_st_t         res;
    t     = {st.rem, bits};
    trial = {{(REM_W - LEN_W){1'b0}}, st.root, 2'b01};
    if (t >= trial) begin
      res.rem  = REM_W'(t - trial);
      res.root = {st.root[LEN_W-2:0], 1'b1};
    end else begin
      res.rem  = REM_W'(t);
      res.root = {st.root[LEN_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

FILE: rtl/qae_norm.sv
// Pipelined normalization of one quaternion: squares, root, four rounded divides.
module qae_norm (
  input  logic                clk,
  input  logic                en,
  input  qae_pkg::comp_t      q_in  [4],
  output qae_pkg::nrm_t       n_out [4],
  output logic                zero_out
);

  localparam int SS = qae_pkg::SQRT_STEPS;
  localparam int DS = qae_pkg::DIV_STEPS;
  localparam int LW = qae_pkg::LEN_W;
  localparam int FB = qae_pkg::FRAC_BITS;

  // squares
  qae_pkg::comp_t            q1_r  [4];
  logic [qae_pkg::SQ_W-1:0]  sq1_r [4];
  // sum of squares
  qae_pkg::comp_t            q2_r  [4];
  logic [qae_pkg::SUM_W-1:0] sum2_r;
  logic                      zero2_r;
  // root stages
  qae_pkg::comp_t            qs_r   [SS][4];
  qae_pkg::sqrt_st_t         sst_r  [SS];
  logic [qae_pkg::SQRT_IN_W-1:0] srad_r [SS];
  logic                      szero_r [SS];
  // divider setup
  logic [LW-1:0]             len_p_r;
  logic [qae_pkg::NUM_W-1:0] num_p_r [4];
  logic                      neg_p_r [4];
  logic                      zero_p_r;
  // divide stages
  logic [LW-1:0]             drem_r  [DS][4];
  logic [DS-1:0]             dlow_r  [DS][4];
  logic [DS-1:0]             dquo_r  [DS][4];
  logic                      dneg_r  [DS][4];
  logic [LW-1:0]             dlen_r  [DS];
  logic                      dzero_r [DS];
  // output
  qae_pkg::nrm_t             n_r [4];
  logic                      zero_r;

  logic signed [2*qae_pkg::IN_W-1:0] sq_nxt [4];
  logic [qae_pkg::SUM_W-1:0]     sum_nxt;
  logic [LW-1:0]                 len_nxt;
  logic [qae_pkg::SQRT_IN_W-1:0] rad0;
  logic [qae_pkg::MAG_W-1:0]     mag_nxt [4];

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      sq_nxt[i]  = q_in[i] * q_in[i];
      sum_nxt    = sum_nxt + qae_pkg::SUM_W'(sq1_r[i]);
      // |q| as unsigned; the most negative code gives 2^15
      mag_nxt[i] = qs_r[SS-1][i][qae_pkg::IN_W-1] ? -qs_r[SS-1][i] : qs_r[SS-1][i];
    end
    len_nxt = sst_r[SS-1].root;
    rad0    = qae_pkg::SQRT_IN_W'(sum2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q1_r[i]  <= q_in[i];
        sq1_r[i] <= sq_nxt[i][qae_pkg::SQ_W-1:0];
        q2_r[i]  <= q1_r[i];
      end
      sum2_r  <= sum_nxt;
      zero2_r <= (sum_nxt == '0);
      // rounding offset L/2 added to |q| * 2^F, rounding half away from zero
      len_p_r  <= len_nxt;
      zero_p_r <= szero_r[SS-1];
      for (int i = 0; i < 4; i++) begin
        neg_p_r[i] <= qs_r[SS-1][i][qae_pkg::IN_W-1];
        num_p_r[i] <= qae_pkg::NUM_W'({mag_nxt[i], {FB{1'b0}}})
                      + qae_pkg::NUM_W'(len_nxt >> 1);
      end
      zero_r <= dzero_r[DS-1];
      for (int i = 0; i < 4; i++) begin
        n_r[i] <= dneg_r[DS-1][i] ? -qae_pkg::nrm_t'({1'b0, dquo_r[DS-1][i]})
                                  :  qae_pkg::nrm_t'({1'b0, dquo_r[DS-1][i]});
      end
    end
  end

  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          qs_r[j]    <= q2_r;
          sst_r[j]   <= qae_pkg::sqrt_step('0, rad0[qae_pkg::SQRT_IN_W-1 -: 2]);
          srad_r[j]  <= rad0 << 2;
          szero_r[j] <= zero2_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          qs_r[j]    <= qs_r[j-1];
          sst_r[j]   <= qae_pkg::sqrt_step(sst_r[j-1],
                          srad_r[j-1][qae_pkg::SQRT_IN_W-1 -: 2]);
          srad_r[j]  <= srad_r[j-1] << 2;
          szero_r[j] <= szero_r[j-1];
        end
      end
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [LW-1:0] rem_in  [4];
    logic [DS-1:0] low_in  [4];
    logic [DS-1:0] quo_in  [4];
    logic          neg_in  [4];
    logic [LW-1:0] len_in;
    logic          zero_in;
    logic [LW:0]   t       [4];

    if (j == 0) begin : g_first
      always_comb begin
        len_in  = len_p_r;
        zero_in = zero_p_r;
        for (int i = 0; i < 4; i++) begin
          rem_in[i] = LW'(num_p_r[i][qae_pkg::NUM_W-1:DS]);
          low_in[i] = num_p_r[i][DS-1:0];
          quo_in[i] = '0;
          neg_in[i] = neg_p_r[i];
        end
      end
    end else begin : g_rest
      always_comb begin
        len_in  = dlen_r[j-1];
        zero_in = dzero_r[j-1];
        for (int i = 0; i < 4; i++) begin
          rem_in[i] = drem_r[j-1][i];
          low_in[i] = dlow_r[j-1][i];
          quo_in[i] = dquo_r[j-1][i];
          neg_in[i] = dneg_r[j-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t[i] = {rem_in[i], low_in[i][DS-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dlen_r[j]  <= len_in;
        dzero_r[j] <= zero_in;
        for (int i = 0; i < 4; i++) begin
          dneg_r[j][i] <= neg_in[i];
          dlow_r[j][i] <= low_in[i] << 1;
          if (t[i] >= {1'b0, len_in}) begin
            drem_r[j][i] <= LW'(t[i] - {1'b0, len_in});
            dquo_r[j][i] <= {quo_in[i][DS-2:0], 1'b1};
          end else begin
            drem_r[j][i] <= LW'(t[i]);
            dquo_r[j][i] <= {quo_in[i][DS-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign n_out    = n_r;
  assign zero_out = zero_r;

endmodule

FILE: rtl/quaternion_attitude_error.sv
// Top level: small-angle attitude error between a measured and a reference quaternion.
//
// Input channel (in_*): one transfer carries both quaternions, scalar first,
// signed Q2.14. Output channel (out_*): one transfer per input transfer, in
// order, with twice the error vector part (Q2.14, saturated) in tdata and the
// hemisphere-flip and zero-length flags in tuser.
// Each quaternion is normalized by its length (17-stage pipelined square root,
// then four 15-stage pipelined rounded divides), the error quaternion
// conj(ref) * meas is formed from 16 registered products, the vector is
// negated when the error scalar is negative, then rounded and saturated.
// Throughput: one transfer per cycle while the receiver does not stall. The
// pipeline holds 40 registers from the input transfer to out_tvalid (root
// and divide stages dominate, one result bit per stage).
// Reset clears all valid bits; the pipeline then runs empty and in_tready is
// high. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_tready drops in the same cycle; nothing is dropped or repeated.
// A zero-length input quaternion gives zero error with degenerate set.
module quaternion_attitude_error (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // meas_q_w, meas_q_x, meas_q_y, meas_q_z, ref_q_w, ref_q_x, ref_q_y, ref_q_z
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // angle_err_x, angle_err_y, angle_err_z
  output logic [47:0]  out_tdata,
  // hemisphere_flipped, degenerate
  output logic [1:0]   out_tuser
);

  localparam int DEPTH = qae_pkg::PIPE_DEPTH;
  localparam int FB    = qae_pkg::FRAC_BITS;
  localparam int AW    = qae_pkg::ACC_W;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;

  qae_pkg::comp_t mq_r [4];
  qae_pkg::comp_t rq_r [4];
  qae_pkg::nrm_t  mn   [4];
  qae_pkg::nrm_t  rn   [4];
  logic           mzero, rzero;

  // products r[a] * m[b]
  logic signed [qae_pkg::PROD_W-1:0] p_r [4][4];
  logic                              pz_r;
  logic signed [AW-1:0]              s_r, v_r [3];
  logic                              sz_r;
  logic signed [qae_pkg::OUT_W-1:0]  err_r [3];
  logic                              flip_r, deg_r;

  logic signed [AW-1:0] s_nxt;
  logic signed [AW-1:0] v_nxt [3];
  logic signed [AW-1:0] vf    [3];
  logic signed [AW-1:0] t     [3];
  logic signed [qae_pkg::OUT_W-1:0] err_nxt [3];

  // global advance: hold everything while a result waits on a stalled receiver
  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mq_r[i] <= in_tdata[16*i +: 16];
        rq_r[i] <= in_tdata[64 + 16*i +: 16];
      end
    end
  end

  qae_norm u_norm_meas (
    .clk      (clk),
    .en       (en),
    .q_in     (mq_r),
    .n_out    (mn),
    .zero_out (mzero)
  );

  qae_norm u_norm_ref (
    .clk      (clk),
    .en       (en),
    .q_in     (rq_r),
    .n_out    (rn),
    .zero_out (rzero)
  );

  // Hamilton product conj(r) * m
  always_comb begin
    s_nxt = AW'(p_r[0][0]) + AW'(p_r[1][1]) + AW'(p_r[2][2]) + AW'(p_r[3][3]);
    v_nxt[0] = AW'(p_r[0][1]) - AW'(p_r[1][0]) - AW'(p_r[2][3]) + AW'(p_r[3][2]);
    v_nxt[1] = AW'(p_r[0][2]) - AW'(p_r[2][0]) - AW'(p_r[3][1]) + AW'(p_r[1][3]);
    v_nxt[2] = AW'(p_r[0][3]) - AW'(p_r[3][0]) - AW'(p_r[1][2]) + AW'(p_r[2][1]);
    for (int i = 0; i < 3; i++) begin
      vf[i] = s_r[AW-1] ? -v_r[i] : v_r[i];
      // 2*v rounded half up to FRAC_BITS: floor((v + 2^(F-2)) / 2^(F-1))
      t[i]  = (vf[i] + (AW'(1) <<< (FB - 2))) >>> (FB - 1);
      if (t[i] > AW'(32767)) begin
        err_nxt[i] = 16'sh7FFF;
      end else if (t[i] < -AW'(32768)) begin
        err_nxt[i] = 16'sh8000;
      end else begin
        err_nxt[i] = qae_pkg::OUT_W'(t[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          p_r[a][b] <= rn[a] * mn[b];
        end
      end
      pz_r <= mzero || rzero;
      s_r  <= s_nxt;
      v_r  <= v_nxt;
      sz_r <= pz_r;
      deg_r  <= sz_r;
      flip_r <= !sz_r && s_r[AW-1];
      for (int i = 0; i < 3; i++) begin
        err_r[i] <= sz_r ? '0 : err_nxt[i];
      end
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {err_r[2], err_r[1], err_r[0]};
  assign out_tuser  = {deg_r, flip_r};

endmodule

FILE: verif/quaternion_attitude_error_checker.sv
// Checker for the quaternion attitude error block: predicts each result and compares it.
module quaternion_attitude_error_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic       degenerate;
    logic       flipped;
    logic [15:0] err_z;
    logic [15:0] err_y;
    logic [15:0] err_x;
  } attitude_err_t;

  attitude_err_t expected_errs[$];

  // restoring integer square root
  function automatic longint root_floor(longint s);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // quotient rounded half away from zero
  function automatic longint div_round(longint a, longint d);
    if (a >= 0) return (a + d / 2) / d;
    return -((-a + d / 2) / d);
  endfunction

  function automatic logic [15:0] clamp16(longint x);
    if (x > 32767) return 16'h7fff;
    if (x < -32768) return 16'h8000;
    return x[15:0];
  endfunction

  function automatic attitude_err_t predict_error(logic [127:0] d);
    longint mq[4], rq[4], m[4], r[4], v[3];
    longint sm, sr, lm, lr, s, t;
    attitude_err_t res;
    sm = 0;
    sr = 0;
    for (int i = 0; i < 4; i++) begin
      mq[i] = longint'($signed(d[16*i +: 16]));
      rq[i] = longint'($signed(d[16*(i+4) +: 16]));
      sm += mq[i] * mq[i];
      sr += rq[i] * rq[i];
    end
    res = '0;
    if (sm == 0 || sr == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    lm = root_floor(sm);
    lr = root_floor(sr);
    for (int i = 0; i < 4; i++) begin
      m[i] = div_round(mq[i] <<< qae_pkg::FRAC_BITS, lm);
      r[i] = div_round(rq[i] <<< qae_pkg::FRAC_BITS, lr);
    end
    s    = r[0]*m[0] + r[1]*m[1] + r[2]*m[2] + r[3]*m[3];
    v[0] = r[0]*m[1] - m[0]*r[1] - (r[2]*m[3] - r[3]*m[2]);
    v[1] = r[0]*m[2] - m[0]*r[2] - (r[3]*m[1] - r[1]*m[3]);
    v[2] = r[0]*m[3] - m[0]*r[3] - (r[1]*m[2] - r[2]*m[1]);
    if (s < 0) begin
      res.flipped = 1'b1;
      for (int i = 0; i < 3; i++) v[i] = -v[i];
    end
    // twice v, rounded half up: arithmetic shift is a floor
    t = (v[0] + (64'sd1 <<< (qae_pkg::FRAC_BITS - 2))) >>> (qae_pkg::FRAC_BITS - 1);
    res.err_x = clamp16(t);
    t = (v[1] + (64'sd1 <<< (qae_pkg::FRAC_BITS - 2))) >>> (qae_pkg::FRAC_BITS - 1);
    res.err_y = clamp16(t);
    t = (v[2] + (64'sd1 <<< (qae_pkg::FRAC_BITS - 2))) >>> (qae_pkg::FRAC_BITS - 1);
    res.err_z = clamp16(t);
    return res;
  endfunction

  assign pending_count = expected_errs.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    attitude_err_t want;
    attitude_err_t got;
    if (rst_n && in_tvalid && in_tready) expected_errs.push_back(predict_error(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[1], out_tuser[0], out_tdata};
      if (expected_errs.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_errs.pop_front();
        if (got.err_x !== want.err_x) begin
          $error("angle_err_x: expected %0d, got %0d", $signed(want.err_x), $signed(got.err_x));
          fail_count++;
        end
        if (got.err_y !== want.err_y) begin
          $error("angle_err_y: expected %0d, got %0d", $signed(want.err_y), $signed(got.err_y));
          fail_count++;
        end
        if (got.err_z !== want.err_z) begin
          $error("angle_err_z: expected %0d, got %0d", $signed(want.err_z), $signed(got.err_z));
          fail_count++;
        end
        if (got.flipped !== want.flipped) begin
          $error("hemisphere_flipped: expected %0b, got %0b", want.flipped, got.flipped);
          fail_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: verif/quaternion_attitude_error_tb.sv
// Testbench top: drives quaternion pairs with random gaps and stalls, reports the verdict.
module quaternion_attitude_error_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending_count;
  logic         stim_done;

  quaternion_attitude_error i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  quaternion_attitude_error_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random 16-bit component, biased toward the extremes and zero
  function automatic logic [15:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  // unit-ish quaternion near a chosen one, Q2.14
  function automatic logic [63:0] near_quat(logic [63:0] q);
    logic [63:0] res;
    int spread;
    spread = 1 << $urandom_range(0, 12);
    for (int i = 0; i < 4; i++)
      res[16*i +: 16] = q[16*i +: 16] + 16'($urandom_range(0, 2*spread) - spread);
    return res;
  endfunction

  function automatic logic [127:0] random_pair();
    logic [63:0] m, r;
    case ($urandom_range(0, 5))
      0, 1: begin
        // realistic: reference close to measured, either hemisphere
        for (int i = 0; i < 4; i++) m[16*i +: 16] = 16'($urandom_range(0, 32767) - 16384);
        r = near_quat(m);
        if ($urandom_range(0, 1)) for (int i = 0; i < 4; i++) r[16*i +: 16] = -r[16*i +: 16];
      end
      2: begin
        // one side of zero length now and then
        for (int i = 0; i < 4; i++) m[16*i +: 16] = pick_component();
        r = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'({$urandom(), $urandom()});
        if ($urandom_range(0, 1)) {m, r} = {r, m};
      end
      3: for (int i = 0; i < 4; i++) begin
        m[16*i +: 16] = pick_component();
        r[16*i +: 16] = pick_component();
      end
      default: begin
        m = {$urandom(), $urandom()};
        r = {$urandom(), $urandom()};
      end
    endcase
    return {r, m};
  endfunction

  // hold one transfer until the block takes it
  task automatic send_pair(logic [127:0] d);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // idle gap between bursts
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stall pattern: long free runs, bursts of stalls, and a toggling mode
  initial begin
    int mode;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [127:0] directed[$];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length on either side, and both
    directed.push_back({64'h0, 64'h0000_0000_0000_4000});
    directed.push_back({64'h0000_0000_0000_4000, 64'h0});
    directed.push_back(128'h0);
    // identity vs identity, and a hemisphere flip of the same rotation
    directed.push_back({64'h0000_0000_0000_4000, 64'h0000_0000_0000_4000});
    directed.push_back({64'h0000_0000_0000_c000, 64'h0000_0000_0000_4000});
    // error scalar exactly zero: orthogonal quaternions
    directed.push_back({64'h0000_0000_4000_0000, 64'h0000_0000_0000_4000});
    directed.push_back({64'h4000_0000_0000_0000, 64'h0000_0000_0000_4000});
    // extremes of every component
    directed.push_back({64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000});
    directed.push_back({64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff});
    directed.push_back({64'h8000_0000_0000_0000, 64'h0000_0000_0000_7fff});
    directed.push_back({64'h0001_0000_0000_0000, 64'h0000_0000_0000_ffff});
    directed.push_back({64'hffff_ffff_ffff_ffff, 64'h0001_0001_0001_0001});
    // large errors
    directed.push_back({64'h0000_0000_0000_4000, 64'h0000_2d41_2d41_2d41});
    directed.push_back({64'h0000_0000_0000_4000, 64'h0000_d2bf_d2bf_d2bf});
    directed.push_back({64'h3ff0_0010_fff0_4000, 64'h0001_0002_0003_4000});
    directed.push_back({64'h0000_7fff_8000_7fff, 64'h7fff_0000_7fff_8000});
    foreach (directed[i]) begin
      send_pair(directed[i]);
      if ($urandom_range(0, 1)) sender_gap();
    end

    for (int k = 0; k < 550; ) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++) send_pair(random_pair());
      k += burst;
      sender_gap();
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // verdict: drain, then allow the pipeline latency to expose extra results
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
